>>> hw/rtl/dmcht_pkg.sv
// ----------------------------------------------------------------------------
// dmcht_pkg
// Shared types and constants of the direct-mapped cache hit tracker.
// ----------------------------------------------------------------------------
package dmcht_pkg;

  // Default geometry
  localparam int NUM_LINES_DEF  = 256;

  // Field widths
  localparam int ADDR_W  = 32;   // input address field
  localparam int IDX_W   = 8;    // line index field
  localparam int CNT_W   = 32;   // access / hit / miss counters
  localparam int AMAT_W  = 9;    // average access time result
  localparam int OB_W    = 5;    // offset_bits register
  localparam int IB_W    = 4;    // index_bits register
  localparam int HC_W    = 8;    // hit_cycles register
  localparam int TDATA_W = 152;  // result beat, padded to whole bytes

  // Saturation limits of the split widths
  localparam logic [OB_W-1:0] OB_MAX = 5'd16;
  localparam logic [IB_W-1:0] IB_MAX = 4'd8;

  // Miss penalty and ratio divider sizing; quotient stays below 128
  localparam int MEM_PENALTY = 120;
  localparam int QUOT_W      = 7;
  localparam int DIVD_W      = CNT_W + QUOT_W;
  localparam int STEP_W      = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_OFFSET_BITS = 2'd0,
    REG_INDEX_BITS  = 2'd1,
    REG_HIT_CYCLES  = 2'd2
  } reg_idx_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_COMPARE,
    ST_DIV_START,
    ST_DIV_WAIT
  } state_e;

  // Divider status toward the sequencer
  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_res_t;

endpackage

>>> hw/rtl/dmcht_div.sv
// ----------------------------------------------------------------------------
// dmcht_div
// Restoring divider, one quotient bit per cycle, for quotients below 2^QUOT_W.
// ----------------------------------------------------------------------------
module dmcht_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [dmcht_pkg::DIVD_W-1:0]   dividend_i,
  input  logic [dmcht_pkg::CNT_W-1:0]    divisor_i,
  output dmcht_pkg::div_res_t            res_o
);

  logic [dmcht_pkg::DIVD_W-1:0] rem_q, rem_d;
  logic [dmcht_pkg::DIVD_W-1:0] den_q, den_d;
  logic [dmcht_pkg::QUOT_W-1:0] quot_q, quot_d;
  logic [dmcht_pkg::STEP_W-1:0] step_q, step_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic                         ge;

  // One compare and subtract per cycle
  assign ge = (rem_q >= den_q);

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      rem_d  = dividend_i;
      den_d  = dmcht_pkg::DIVD_W'(divisor_i) << (dmcht_pkg::QUOT_W - 1);
      quot_d = '0;
      step_d = dmcht_pkg::STEP_W'(dmcht_pkg::QUOT_W - 1);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - den_q;
      end
      quot_d = {quot_q[dmcht_pkg::QUOT_W-2:0], ge};
      den_d  = den_q >> 1;
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath flops
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = quot_q;

endmodule

>>> hw/rtl/direct_mapped_cache_hit_tracker_top.sv
// ----------------------------------------------------------------------------
// direct_mapped_cache_hit_tracker_top
// Direct-mapped cache model with hit/miss counters and average access time.
// ----------------------------------------------------------------------------
// Each input beat carries one byte address. The address is split into offset,
// line index and tag by the offset_bits and index_bits registers; the line's
// valid bit and stored tag decide hit or miss, and a miss refills the line.
// Every access returns one result beat with the saturating access, hit and
// miss totals and hit_cycles + floor(120*misses/accesses). An accepted address
// passes address split and tag RAM read, compare and counter update, divider
// start, a 7-step serial divider for the miss ratio, and the output load. The
// input is not ready during that time, and the load waits while an earlier
// result is still stalled; a finished result waits in an output register, so
// the next address can be taken while it is still pending. Valid bits clear
// at reset, no clearing pass is needed. Configuration is APB at byte
// addresses 0, 4 and 8.
// ----------------------------------------------------------------------------
module direct_mapped_cache_hit_tracker_top #(
  parameter int NUM_LINES  = dmcht_pkg::NUM_LINES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream; tdata: address[31:0]
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [dmcht_pkg::ADDR_W-1:0]    s_axis_tdata_i,
  // Result stream; tdata: line_index[7:0], tag_value[39:8], access_total[71:40],
  // hit_total[103:72], miss_total[135:104], amat_cycles[144:136], zero[151:145]
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [dmcht_pkg::TDATA_W-1:0]   m_axis_tdata_o,
  // tuser: hit[0]
  output logic [0:0]                      m_axis_tuser_o,
  // Configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [3:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int IdxLines  = 2 ** dmcht_pkg::IDX_W;
  localparam int UsedLines = (NUM_LINES < IdxLines) ? NUM_LINES : IdxLines;
  localparam int LineW     = (UsedLines > 1) ? $clog2(UsedLines) : 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [dmcht_pkg::OB_W-1:0] offset_bits_q;
  logic [dmcht_pkg::IB_W-1:0] index_bits_q;
  logic [dmcht_pkg::HC_W-1:0] hit_cycles_q;
  logic                       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= 5'd4;
      index_bits_q  <= 4'd4;
      hit_cycles_q  <= 8'd1;
    end else if (cfg_we) begin
      case (paddr[3:2])
        dmcht_pkg::REG_OFFSET_BITS: offset_bits_q <= pwdata[dmcht_pkg::OB_W-1:0];
        dmcht_pkg::REG_INDEX_BITS:  index_bits_q  <= pwdata[dmcht_pkg::IB_W-1:0];
        dmcht_pkg::REG_HIT_CYCLES:  hit_cycles_q  <= pwdata[dmcht_pkg::HC_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[3:2])
      dmcht_pkg::REG_OFFSET_BITS: prdata = 32'(offset_bits_q);
      dmcht_pkg::REG_INDEX_BITS:  prdata = 32'(index_bits_q);
      dmcht_pkg::REG_HIT_CYCLES:  prdata = 32'(hit_cycles_q);
      default:                    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer state and beat handshakes
  // --------------------------------------------------------------------------
  dmcht_pkg::state_e state_q, state_d;
  logic               s_beat;
  logic               tag_re, cmp_en, div_start, out_load;
  logic               out_valid_q, out_valid_d;
  dmcht_pkg::div_res_t div_res;

  assign s_beat = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    tag_re          = 1'b0;
    cmp_en          = 1'b0;
    div_start       = 1'b0;
    out_load        = 1'b0;
    case (state_q)
      dmcht_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) state_d = dmcht_pkg::ST_LOOKUP;
      end
      dmcht_pkg::ST_LOOKUP: begin
        tag_re  = 1'b1;
        state_d = dmcht_pkg::ST_COMPARE;
      end
      dmcht_pkg::ST_COMPARE: begin
        cmp_en  = 1'b1;
        state_d = dmcht_pkg::ST_DIV_START;
      end
      dmcht_pkg::ST_DIV_START: begin
        div_start = 1'b1;
        state_d   = dmcht_pkg::ST_DIV_WAIT;
      end
      dmcht_pkg::ST_DIV_WAIT: begin
        if (div_res.done && (!out_valid_q || m_axis_tready_i)) begin
          out_load = 1'b1;
          state_d  = dmcht_pkg::ST_IDLE;
        end
      end
      default: state_d = dmcht_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmcht_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Address split
  // --------------------------------------------------------------------------
  logic [dmcht_pkg::ADDR_W-1:0] addr_q;
  logic [dmcht_pkg::ADDR_W-1:0] addr_m;
  logic [dmcht_pkg::ADDR_W-1:0] addr_sh;
  logic [dmcht_pkg::OB_W-1:0]   ob_eff;
  logic [dmcht_pkg::IB_W-1:0]   ib_eff;
  logic [dmcht_pkg::OB_W-1:0]   split_sh;
  logic [dmcht_pkg::IDX_W-1:0]  idx_mask, idx_d, idx_q;
  logic [dmcht_pkg::ADDR_W-1:0] tag_d, tag_q;
  logic [LineW-1:0]             line_d, line_q;
  logic [LineW-1:0]             line_lut [IdxLines];

  always_ff @(posedge clk_i) begin
    if (s_beat) addr_q <= s_axis_tdata_i;
  end

  // Index to line folding, worked out at elaboration
  for (genvar g = 0; g < IdxLines; g++) begin : g_line_lut
    assign line_lut[g] = LineW'(g % NUM_LINES);
  end

  always_comb begin
    addr_m   = addr_q;
    ob_eff   = (offset_bits_q > dmcht_pkg::OB_MAX) ? dmcht_pkg::OB_MAX : offset_bits_q;
    ib_eff   = (index_bits_q > dmcht_pkg::IB_MAX) ? dmcht_pkg::IB_MAX : index_bits_q;
    split_sh = ob_eff + dmcht_pkg::OB_W'(ib_eff);
    addr_sh  = addr_m >> ob_eff;
    idx_mask = dmcht_pkg::IDX_W'((9'd1 << ib_eff) - 9'd1);
    idx_d    = addr_sh[dmcht_pkg::IDX_W-1:0] & idx_mask;
    tag_d    = addr_m >> split_sh;
    line_d   = line_lut[idx_d];
  end

  always_ff @(posedge clk_i) begin
    if (tag_re) begin
      idx_q  <= idx_d;
      tag_q  <= tag_d;
      line_q <= line_d;
    end
  end

  // --------------------------------------------------------------------------
  // Tag RAM and valid bits
  // --------------------------------------------------------------------------
  logic [dmcht_pkg::ADDR_W-1:0] tag_mem [UsedLines];
  logic [dmcht_pkg::ADDR_W-1:0] tag_rd_q;
  logic [UsedLines-1:0]         valid_q;
  logic                         hit;
  logic                         hit_q;

  assign hit = valid_q[line_q] && (tag_rd_q == tag_q);

  always_ff @(posedge clk_i) begin
    if (tag_re) tag_rd_q <= tag_mem[line_d];
    if (cmp_en && !hit) tag_mem[line_q] <= tag_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmp_en) begin
      valid_q[line_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_en) hit_q <= hit;
  end

  // --------------------------------------------------------------------------
  // Saturating counters
  // --------------------------------------------------------------------------
  logic [dmcht_pkg::CNT_W-1:0] acc_cnt_q, hit_cnt_q, miss_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_cnt_q  <= '0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
    end else if (cmp_en) begin
      if (acc_cnt_q != dmcht_pkg::CNT_MAX) acc_cnt_q <= acc_cnt_q + 1'b1;
      if (hit) begin
        if (hit_cnt_q != dmcht_pkg::CNT_MAX) hit_cnt_q <= hit_cnt_q + 1'b1;
      end else begin
        if (miss_cnt_q != dmcht_pkg::CNT_MAX) miss_cnt_q <= miss_cnt_q + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Miss ratio: floor(120 * misses / accesses)
  // --------------------------------------------------------------------------
  logic [dmcht_pkg::DIVD_W-1:0] dividend;

  assign dividend = dmcht_pkg::DIVD_W'(miss_cnt_q) *
                    dmcht_pkg::DIVD_W'(dmcht_pkg::MEM_PENALTY);

  dmcht_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (acc_cnt_q),
    .res_o      (div_res)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [dmcht_pkg::AMAT_W-1:0]  amat;
  logic [dmcht_pkg::TDATA_W-1:0] out_data_q;
  logic                          out_hit_q;

  assign amat = dmcht_pkg::AMAT_W'(hit_cycles_q) + dmcht_pkg::AMAT_W'(div_res.quot);

  assign out_valid_d = out_load ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_hit_q  <= hit_q;
      out_data_q <= {7'd0, amat, miss_cnt_q, hit_cnt_q, acc_cnt_q, tag_q, idx_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_hit_q;

endmodule

>>> hw/rtl/dmcht_checker.sv
// ----------------------------------------------------------------------------
// dmcht_checker
// Port-level checks of the cache hit tracker, bound to the top level.
// ----------------------------------------------------------------------------
module dmcht_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [dmcht_pkg::TDATA_W-1:0] m_axis_tdata_o,
  input logic [0:0]                    m_axis_tuser_o
);

  logic [dmcht_pkg::CNT_W-1:0] acc_tot, hit_tot, miss_tot;

  assign acc_tot  = m_axis_tdata_o[71:40];
  assign hit_tot  = m_axis_tdata_o[103:72];
  assign miss_tot = m_axis_tdata_o[135:104];

  // One address at a time: no new beat right after an accepted one
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input ready right after an accepted beat");

  // A stalled result beat holds its payload
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("result beat changed while stalled");

  // Totals stay consistent: accesses cover misses and hits, never zero
  a_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (acc_tot != '0 && acc_tot >= miss_tot && acc_tot >= hit_tot))
    else $error("inconsistent access totals");

  // A hit beat cannot carry a zero hit total, a miss beat a zero miss total
  a_flag_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o[0] ? (hit_tot != '0) : (miss_tot != '0)))
    else $error("hit flag disagrees with totals");

endmodule

bind direct_mapped_cache_hit_tracker_top dmcht_checker u_dmcht_checker (.*);
